[rtl/i2crs_pkg.sv]
`default_nettype none

package i2crs_pkg;

    // Sequencer phase codes
    localparam logic [2:0] PH_ADDR_WRITE = 3'd0;
    localparam logic [2:0] PH_REG_ADDR   = 3'd1;
    localparam logic [2:0] PH_START_READ = 3'd2;
    localparam logic [2:0] PH_READ_BYTE  = 3'd3;
    localparam logic [2:0] PH_READ_LAST  = 3'd4;
    localparam logic [2:0] PH_END        = 3'd5;

    // Transfer status codes
    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_BUSY   = 2'd1;
    localparam logic [1:0] ST_FAILED = 2'd2;

    // Controller action codes
    localparam logic [1:0] ACT_NONE  = 2'd0;
    localparam logic [1:0] ACT_SET   = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    // Request command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_EVENT = 1'b1;

    // Register map
    localparam logic       REG_INCR_MASK   = 1'b0;
    localparam logic [7:0] INCR_MASK_RESET = 8'h80;

    typedef struct packed {
        logic       command;
        logic [7:0] device_address;
        logic [7:0] register_address;
        logic [7:0] byte_count;
        logic       nack_seen;
        logic       data_ready;
        logic [7:0] received_byte;
    } t_request;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       start_condition;
        logic       stop_condition;
        logic       flush_request;
        logic       nak_request;
        logic [1:0] tx_irq_action;
        logic [1:0] bus_enable_action;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic [7:0] rx_index;
        logic [1:0] status;
    } t_result;

endpackage

`default_nettype wire

[rtl/i2c_register_read_sequencer_unit.sv]
// I2C register-read sequencer.
// Request channel (i_valid / o_stall): either a start command carrying the
// device address, first register and byte count, or a controller event
// carrying the nack and ready flags and the received byte.
// Result channel (o_valid / i_stall): one result per request with the data
// byte to transmit, the start/stop/flush/NAK strobes, interrupt and enable
// actions, any received byte with its index, and the transfer status.
// Configuration: APB port, one register (auto-increment mask) at address 0.
// A request accepted into the input register moves on into the result
// register, from which it is taken. Throughput is one request per cycle
// while the receiver does not stall; the phase state updates as a request
// moves into the result register.
// When the receiver stalls, the held result stays put and one more request
// can be taken into the input register; o_stall then rises.
// Reset (synchronous, active low) empties both registers, sets the phase to
// end of cycle, the status to done and the auto-increment mask to 0x80.
`default_nettype none

module i2c_register_read_sequencer_unit
    import i2crs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request channel
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_command,
    input  wire logic [7:0]  i_device_address,
    input  wire logic [7:0]  i_register_address,
    input  wire logic [7:0]  i_byte_count,
    input  wire logic        i_nack_seen,
    input  wire logic        i_data_ready,
    input  wire logic [7:0]  i_received_byte,
    // result channel
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_tx_valid,
    output logic      [7:0]  o_tx_byte,
    output logic             o_start_condition,
    output logic             o_stop_condition,
    output logic             o_flush_request,
    output logic             o_nak_request,
    output logic      [1:0]  o_tx_irq_action,
    output logic      [1:0]  o_bus_enable_action,
    output logic             o_rx_valid,
    output logic      [7:0]  o_rx_byte,
    output logic      [7:0]  o_rx_index,
    output logic      [1:0]  o_status,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    logic     r_in_valid;
    t_request r_in;
    logic     accept;
    logic     step;
    logic     take;
    logic     out_valid;
    logic [7:0] incr_mask;
    t_result  step_result;
    t_result  out_result;

    // Handshake
    assign take    = out_valid && !i_stall;
    assign step    = r_in_valid && (!out_valid || !i_stall);
    assign o_stall = r_in_valid && !(!out_valid || !i_stall);
    assign accept  = i_valid && !o_stall;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in.command          <= i_command;
            r_in.device_address   <= i_device_address;
            r_in.register_address <= i_register_address;
            r_in.byte_count       <= i_byte_count;
            r_in.nack_seen        <= i_nack_seen;
            r_in.data_ready       <= i_data_ready;
            r_in.received_byte    <= i_received_byte;
        end
    end

    i2crs_apb_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_incr_mask (incr_mask)
    );

    i2crs_seq_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (step),
        .i_req       (r_in),
        .i_incr_mask (incr_mask),
        .o_result    (step_result)
    );

    i2crs_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (step),
        .i_take   (take),
        .i_result (step_result),
        .o_valid  (out_valid),
        .o_result (out_result)
    );

    // Result fields
    assign o_valid             = out_valid;
    assign o_tx_valid          = out_result.tx_valid;
    assign o_tx_byte           = out_result.tx_byte;
    assign o_start_condition   = out_result.start_condition;
    assign o_stop_condition    = out_result.stop_condition;
    assign o_flush_request     = out_result.flush_request;
    assign o_nak_request       = out_result.nak_request;
    assign o_tx_irq_action     = out_result.tx_irq_action;
    assign o_bus_enable_action = out_result.bus_enable_action;
    assign o_rx_valid          = out_result.rx_valid;
    assign o_rx_byte           = out_result.rx_byte;
    assign o_rx_index          = out_result.rx_index;
    assign o_status            = out_result.status;

    // Checks
    a_tx_rx_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_tx_valid && o_rx_valid))
        else $error("transmit and receive in one result");

    a_flush_fails: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_flush_request) |-> (o_status == ST_FAILED))
        else $error("flush without failed status");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && (r_in.command == CMD_START)) |=> (o_valid && (o_status == ST_BUSY)))
        else $error("start did not report busy");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && out_valid))
        else $error("stall with room to spare");

endmodule

`default_nettype wire

[rtl/i2crs_apb_regs.sv]
`default_nettype none

module i2crs_apb_regs
    import i2crs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output logic      [7:0]  o_incr_mask
);

    logic [7:0] r_incr_mask;
    logic       wr_en;

    // Write strobe on the access phase
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_INCR_MASK);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_incr_mask <= INCR_MASK_RESET;
        end else if (wr_en) begin
            r_incr_mask <= pwdata[7:0];
        end
    end

    // Read-back; unmapped addresses read as zero
    always_comb begin
        prdata = 32'd0;
        if (paddr[2] == REG_INCR_MASK) begin
            prdata = {24'd0, r_incr_mask};
        end
    end

    assign o_incr_mask = r_incr_mask;

endmodule

`default_nettype wire

[rtl/i2crs_seq_core.sv]
`default_nettype none

module i2crs_seq_core
    import i2crs_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_fire,
    input  wire t_request   i_req,
    input  wire logic [7:0] i_incr_mask,
    output t_result         o_result
);

    logic [2:0] r_phase,  n_phase;
    logic [1:0] r_status, n_status;
    logic [7:0] r_addr,   n_addr;
    logic [7:0] r_reg,    n_reg;
    logic [7:0] r_remain, n_remain;
    logic [7:0] r_pos,    n_pos;

    // One phase step per request
    always_comb begin
        n_phase  = r_phase;
        n_status = r_status;
        n_addr   = r_addr;
        n_reg    = r_reg;
        n_remain = r_remain;
        n_pos    = r_pos;
        o_result = '0;
        o_result.tx_irq_action     = ACT_NONE;
        o_result.bus_enable_action = ACT_NONE;

        if (i_req.command == CMD_START) begin
            // latch a new transfer, restarting any one in flight
            n_status = ST_BUSY;
            n_addr   = i_req.device_address;
            n_reg    = i_req.register_address;
            n_remain = (i_req.byte_count == 8'd0) ? 8'd1 : i_req.byte_count;
            n_pos    = 8'd0;
            n_phase  = PH_ADDR_WRITE;
            o_result.bus_enable_action = ACT_SET;
            o_result.tx_irq_action     = ACT_SET;
        end else if (i_req.nack_seen) begin
            o_result.stop_condition    = 1'b1;
            o_result.bus_enable_action = ACT_CLEAR;
            n_phase                    = PH_END;
            if (r_phase == PH_READ_LAST) begin
                // final byte is NAKed by us: normal completion
                o_result.rx_valid = 1'b1;
                o_result.rx_byte  = i_req.received_byte;
                o_result.rx_index = r_pos;
                n_status          = ST_DONE;
            end else begin
                o_result.flush_request = 1'b1;
                o_result.tx_irq_action = ACT_CLEAR;
                n_status               = ST_FAILED;
            end
        end else if (i_req.data_ready) begin
            unique case (r_phase)
                PH_ADDR_WRITE: begin
                    o_result.tx_valid        = 1'b1;
                    o_result.tx_byte         = r_addr & 8'hFE;
                    o_result.start_condition = 1'b1;
                    n_phase                  = PH_REG_ADDR;
                end
                PH_REG_ADDR: begin
                    o_result.tx_valid = 1'b1;
                    o_result.tx_byte  = (r_remain > 8'd1) ? (r_reg | i_incr_mask) : r_reg;
                    n_phase           = PH_START_READ;
                end
                PH_START_READ: begin
                    o_result.tx_valid        = 1'b1;
                    o_result.tx_byte         = r_addr | 8'h01;
                    o_result.start_condition = 1'b1;
                    o_result.tx_irq_action   = ACT_CLEAR;
                    if (r_remain == 8'd1) begin
                        n_phase              = PH_READ_LAST;
                        o_result.nak_request = 1'b1;
                    end else begin
                        n_phase = PH_READ_BYTE;
                    end
                end
                PH_READ_BYTE: begin
                    o_result.rx_valid = 1'b1;
                    o_result.rx_byte  = i_req.received_byte;
                    o_result.rx_index = r_pos;
                    n_pos             = r_pos + 8'd1;
                    n_remain          = r_remain - 8'd1;
                    // two left before this byte: next one is the last
                    if (r_remain == 8'd2) begin
                        o_result.nak_request = 1'b1;
                        n_phase              = PH_READ_LAST;
                    end
                end
                default: begin
                end
            endcase
        end
        o_result.status = n_status;
    end

    // State commits as the request moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_END;
            r_status <= ST_DONE;
            r_addr   <= 8'd0;
            r_reg    <= 8'd0;
            r_remain <= 8'd0;
            r_pos    <= 8'd0;
        end else if (i_fire) begin
            r_phase  <= n_phase;
            r_status <= n_status;
            r_addr   <= n_addr;
            r_reg    <= n_reg;
            r_remain <= n_remain;
            r_pos    <= n_pos;
        end
    end

endmodule

`default_nettype wire

[rtl/i2crs_seq_core_top_placeholder.sv]
`default_nettype none

module i2crs_out_stage
    import i2crs_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire logic    i_take,
    input  wire t_result i_result,
    output logic         o_valid,
    output t_result      o_result
);

    logic    r_valid;
    t_result r_result;

    // Result register: loads on a step, empties when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;
    import i2crs_pkg::*;

    localparam int          WATCHDOG_LIMIT = 1000;
    localparam int          LONG_HOLD      = 80;
    localparam logic [2:0]  ADDR_INCR_MASK = 3'(REG_INCR_MASK) << 2;
    localparam logic [7:0]  READ_FLAG      = 8'h01;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic        i_command;
    logic [7:0]  i_device_address;
    logic [7:0]  i_register_address;
    logic [7:0]  i_byte_count;
    logic        i_nack_seen;
    logic        i_data_ready;
    logic [7:0]  i_received_byte;
    logic        o_valid;
    logic        i_stall;
    logic        o_tx_valid;
    logic [7:0]  o_tx_byte;
    logic        o_start_condition;
    logic        o_stop_condition;
    logic        o_flush_request;
    logic        o_nak_request;
    logic [1:0]  o_tx_irq_action;
    logic [1:0]  o_bus_enable_action;
    logic        o_rx_valid;
    logic [7:0]  o_rx_byte;
    logic [7:0]  o_rx_index;
    logic [1:0]  o_status;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    i2c_register_read_sequencer_unit i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_command          (i_command),
        .i_device_address   (i_device_address),
        .i_register_address (i_register_address),
        .i_byte_count       (i_byte_count),
        .i_nack_seen        (i_nack_seen),
        .i_data_ready       (i_data_ready),
        .i_received_byte    (i_received_byte),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_tx_valid         (o_tx_valid),
        .o_tx_byte          (o_tx_byte),
        .o_start_condition  (o_start_condition),
        .o_stop_condition   (o_stop_condition),
        .o_flush_request    (o_flush_request),
        .o_nak_request      (o_nak_request),
        .o_tx_irq_action    (o_tx_irq_action),
        .o_bus_enable_action(o_bus_enable_action),
        .o_rx_valid         (o_rx_valid),
        .o_rx_byte          (o_rx_byte),
        .o_rx_index         (o_rx_index),
        .o_status           (o_status),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    always #2 i_clk = ~i_clk;

    // Sequencer state as the block should hold it
    logic [7:0] incr_mask_model = INCR_MASK_RESET;
    logic [2:0] seq_phase       = PH_END;
    logic [1:0] seq_status      = ST_DONE;
    logic [7:0] seq_target      = '0;
    logic [7:0] seq_first_reg   = '0;
    logic [7:0] seq_remaining   = '0;
    logic [7:0] seq_position    = '0;

    t_result predicted_outputs[$];
    int      mismatches   = 0;
    int      items_sent   = 0;
    int      idle_cycles  = 0;
    int      tx_gap_max   = 8;
    int      rx_wait_max  = 8;
    bit      long_hold_req = 1'b0;

    // Controller actions for one request; advances the sequencer state
    function automatic t_result predict_sequencer_step(t_request rq);
        t_result r;
        r = '0;
        if (rq.command == CMD_START) begin
            seq_status    = ST_BUSY;
            seq_target    = rq.device_address;
            seq_first_reg = rq.register_address;
            seq_remaining = (rq.byte_count == 8'd0) ? 8'd1 : rq.byte_count;
            seq_position  = '0;
            seq_phase     = PH_ADDR_WRITE;
            r.bus_enable_action = ACT_SET;
            r.tx_irq_action     = ACT_SET;
        end else if (rq.nack_seen) begin
            r.stop_condition    = 1'b1;
            r.bus_enable_action = ACT_CLEAR;
            if (seq_phase == PH_READ_LAST) begin
                // nack on the last byte is the normal end
                r.rx_valid = 1'b1;
                r.rx_byte  = rq.received_byte;
                r.rx_index = seq_position;
                seq_status = ST_DONE;
            end else begin
                r.flush_request = 1'b1;
                r.tx_irq_action = ACT_CLEAR;
                seq_status      = ST_FAILED;
            end
            seq_phase = PH_END;
        end else if (rq.data_ready) begin
            case (seq_phase)
                PH_ADDR_WRITE: begin
                    r.tx_valid        = 1'b1;
                    r.tx_byte         = seq_target & ~READ_FLAG;
                    r.start_condition = 1'b1;
                    seq_phase         = PH_REG_ADDR;
                end
                PH_REG_ADDR: begin
                    r.tx_valid = 1'b1;
                    r.tx_byte  = (seq_remaining > 8'd1) ? (seq_first_reg | incr_mask_model)
                                                        : seq_first_reg;
                    seq_phase  = PH_START_READ;
                end
                PH_START_READ: begin
                    r.tx_valid        = 1'b1;
                    r.tx_byte         = seq_target | READ_FLAG;
                    r.start_condition = 1'b1;
                    r.tx_irq_action   = ACT_CLEAR;
                    if (seq_remaining == 8'd1) begin
                        r.nak_request = 1'b1;
                        seq_phase     = PH_READ_LAST;
                    end else begin
                        seq_phase = PH_READ_BYTE;
                    end
                end
                PH_READ_BYTE: begin
                    r.rx_valid    = 1'b1;
                    r.rx_byte     = rq.received_byte;
                    r.rx_index    = seq_position;
                    seq_position  = seq_position + 8'd1;
                    seq_remaining = seq_remaining - 8'd1;
                    if (seq_remaining == 8'd1) begin
                        r.nak_request = 1'b1;
                        seq_phase     = PH_READ_LAST;
                    end
                end
                default: begin
                end
            endcase
        end
        r.status = seq_status;
        return r;
    endfunction

    function automatic void compare_field(string field, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
            mismatches++;
        end
    endfunction

    // Monitor: predicts on each accepted request, checks each accepted result
    always @(posedge i_clk) begin
        t_request req_seen;
        t_result  want;
        bit       moved;
        moved = 1'b0;
        if (i_rst_n === 1'b1) begin
            if (i_valid && !o_stall) begin
                req_seen.command          = i_command;
                req_seen.device_address   = i_device_address;
                req_seen.register_address = i_register_address;
                req_seen.byte_count       = i_byte_count;
                req_seen.nack_seen        = i_nack_seen;
                req_seen.data_ready       = i_data_ready;
                req_seen.received_byte    = i_received_byte;
                predicted_outputs.push_back(predict_sequencer_step(req_seen));
                moved = 1'b1;
            end
            if (o_valid && !i_stall) begin
                moved = 1'b1;
                if (predicted_outputs.size() == 0) begin
                    $display("%0t: result with nothing expected, status %0h", $time,
                             o_status);
                    mismatches++;
                end else begin
                    want = predicted_outputs.pop_front();
                    compare_field("tx_valid", want.tx_valid, o_tx_valid);
                    compare_field("tx_byte", want.tx_byte, o_tx_byte);
                    compare_field("start_condition", want.start_condition,
                                  o_start_condition);
                    compare_field("stop_condition", want.stop_condition, o_stop_condition);
                    compare_field("flush_request", want.flush_request, o_flush_request);
                    compare_field("nak_request", want.nak_request, o_nak_request);
                    compare_field("tx_irq_action", want.tx_irq_action, o_tx_irq_action);
                    compare_field("bus_enable_action", want.bus_enable_action,
                                  o_bus_enable_action);
                    compare_field("rx_valid", want.rx_valid, o_rx_valid);
                    compare_field("rx_byte", want.rx_byte, o_rx_byte);
                    compare_field("rx_index", want.rx_index, o_rx_index);
                    compare_field("status", want.status, o_status);
                end
            end
            // register access
            if (psel && penable && pready) begin
                moved = 1'b1;
                if (pwrite && paddr == ADDR_INCR_MASK)
                    incr_mask_model = pwdata[7:0];
                else if (!pwrite && paddr == ADDR_INCR_MASK)
                    compare_field("incr_mask", {24'd0, incr_mask_model}, prdata);
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, idle_cycles);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // Result side: random stall per result, one long hold-off on demand
    initial begin
        int hold;
        wait (i_rst_n === 1'b1);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold = LONG_HOLD;
            end else begin
                hold = $urandom_range(0, rx_wait_max);
            end
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
                i_stall <= 1'b0;
            end
            do @(posedge i_clk); while (o_valid !== 1'b1);
        end
    end

    // Offer one request after a random gap and hold it until taken
    task automatic send_request(input t_request rq);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid            <= 1'b1;
        i_command          <= rq.command;
        i_device_address   <= rq.device_address;
        i_register_address <= rq.register_address;
        i_byte_count       <= rq.byte_count;
        i_nack_seen        <= rq.nack_seen;
        i_data_ready       <= rq.data_ready;
        i_received_byte    <= rq.received_byte;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
    endtask

    // Stop offering and wait for every outstanding result
    task automatic wait_for_outputs();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (predicted_outputs.size() != 0);
    endtask

    // Setup phase, access phase, then idle before the next transfer
    task automatic apb_access(input logic write, input logic [2:0] addr,
                              input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_request random_request();
        t_request rq;
        rq.command          = 1'($urandom);
        rq.device_address   = 8'($urandom);
        rq.register_address = 8'($urandom);
        rq.byte_count       = 8'($urandom);
        rq.nack_seen        = 1'($urandom);
        rq.data_ready       = 1'($urandom);
        rq.received_byte    = 8'($urandom);
        return rq;
    endfunction

    function automatic t_request start_request(logic [7:0] dev, logic [7:0] reg_addr,
                                               logic [7:0] count);
        t_request rq;
        rq = random_request();
        rq.command          = CMD_START;
        rq.device_address   = dev;
        rq.register_address = reg_addr;
        rq.byte_count       = count;
        return rq;
    endfunction

    function automatic t_request event_request(logic nack, logic ready);
        t_request rq;
        rq = random_request();
        rq.command    = CMD_EVENT;
        rq.nack_seen  = nack;
        rq.data_ready = ready;
        return rq;
    endfunction

    // One register read from start to final nack, with optional stray events
    // and a nack at a random point in fault_pct percent of transfers
    task automatic run_read_transfer(input logic [7:0] dev, input logic [7:0] reg_addr,
                                     input logic [7:0] count, input int fault_pct);
        int steps;
        int abort_at;
        steps = 3 + ((count == 8'd0) ? 1 : int'(count)) - 1;
        abort_at = ($urandom_range(0, 99) < fault_pct) ? $urandom_range(0, steps - 1) : -1;
        send_request(start_request(dev, reg_addr, count));
        for (int k = 0; k < steps; k++) begin
            if (k == abort_at) begin
                send_request(event_request(1'b1, 1'($urandom)));
                return;
            end
            if ($urandom_range(0, 15) == 0)
                send_request(event_request(1'b0, 1'b0));
            send_request(event_request(1'b0, 1'b1));
        end
        // ready alone in the last-byte phase changes nothing
        if ($urandom_range(0, 7) == 0)
            send_request(event_request(1'b0, 1'b1));
        send_request(event_request(1'b1, 1'($urandom)));
    endtask

    task automatic test_corner_requests();
        t_request rq;
        // idle phase: ready alone, no flag, then nack as an error
        send_request(event_request(1'b0, 1'b1));
        send_request(event_request(1'b0, 1'b0));
        send_request(event_request(1'b1, 1'b0));
        // zero count latched as one, extremes of the address fields
        send_request(start_request(8'hFF, 8'h00, 8'd0));
        send_request(event_request(1'b0, 1'b1));
        send_request(event_request(1'b0, 1'b1));
        send_request(event_request(1'b0, 1'b1));
        send_request(event_request(1'b0, 1'b1));
        send_request(event_request(1'b0, 1'b0));
        rq = event_request(1'b1, 1'b1);
        rq.received_byte = 8'hFF;
        send_request(rq);
        // start while busy restarts the sequence
        send_request(start_request(8'h00, 8'hFF, 8'd255));
        send_request(event_request(1'b0, 1'b1));
        send_request(start_request(8'h5A, 8'h7F, 8'd2));
        send_request(event_request(1'b0, 1'b1));
        send_request(event_request(1'b0, 1'b1));
        send_request(event_request(1'b0, 1'b1));
        rq = event_request(1'b0, 1'b1);
        rq.received_byte = 8'h00;
        send_request(rq);
        send_request(event_request(1'b1, 1'b0));
        // nack during the register address write
        send_request(start_request(8'hA5, 8'h3C, 8'd3));
        send_request(event_request(1'b0, 1'b1));
        send_request(event_request(1'b1, 1'b1));
        // nack while reading the first of two bytes
        send_request(start_request(8'h14, 8'h81, 8'd2));
        send_request(event_request(1'b0, 1'b1));
        send_request(event_request(1'b0, 1'b1));
        send_request(event_request(1'b0, 1'b1));
        send_request(event_request(1'b1, 1'b0));
        wait_for_outputs();
    endtask

    task automatic test_auto_increment_masks();
        logic [7:0] masks[4];
        masks = '{8'h00, 8'hFF, 8'($urandom_range(1, 254)), INCR_MASK_RESET};
        // reset value first
        apb_access(1'b0, ADDR_INCR_MASK, '0);
        foreach (masks[m]) begin
            apb_access(1'b1, ADDR_INCR_MASK, {24'd0, masks[m]});
            apb_access(1'b0, ADDR_INCR_MASK, '0);
            repeat (4)
                run_read_transfer(8'($urandom), 8'($urandom), 8'($urandom_range(0, 3)), 0);
            wait_for_outputs();
        end
    endtask

    task automatic test_long_transfer();
        run_read_transfer(8'hA4, 8'h10, 8'd255, 0);
        wait_for_outputs();
    endtask

    // Result side holds off while requests keep coming, so the input stalls
    task automatic test_output_backpressure();
        tx_gap_max    = 0;
        long_hold_req = 1'b1;
        run_read_transfer(8'h3A, 8'h20, 8'd12, 0);
        wait_for_outputs();
        tx_gap_max = 8;
    endtask

    task automatic test_random_traffic();
        int stop_at;
        int choice;
        int count;
        stop_at = items_sent + 850;
        while (items_sent < stop_at) begin
            // some transfers run with no idling on either side
            if ($urandom_range(0, 5) == 0) begin
                tx_gap_max  = 0;
                rx_wait_max = 0;
            end else begin
                tx_gap_max  = 8;
                rx_wait_max = 8;
            end
            choice = $urandom_range(0, 99);
            if (choice < 80) begin
                count = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 80)
                                                     : $urandom_range(0, 6);
                run_read_transfer(8'($urandom), 8'($urandom), 8'(count), 15);
            end else if (choice < 90) begin
                repeat ($urandom_range(1, 4)) send_request(random_request());
            end else begin
                // start with any count, then a broken tail of events
                send_request(start_request(8'($urandom), 8'($urandom), 8'($urandom)));
                repeat ($urandom_range(0, 5)) begin
                    send_request(event_request(1'b0, 1'b1));
                end
                send_request(event_request(1'($urandom), 1'($urandom)));
            end
        end
        tx_gap_max  = 8;
        rx_wait_max = 8;
        wait_for_outputs();
    endtask

    initial begin
        i_rst_n            <= 1'b0;
        i_valid            <= 1'b0;
        i_stall            <= 1'b0;
        i_command          <= CMD_EVENT;
        i_device_address   <= '0;
        i_register_address <= '0;
        i_byte_count       <= '0;
        i_nack_seen        <= 1'b0;
        i_data_ready       <= 1'b0;
        i_received_byte    <= '0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_corner_requests();
        test_auto_increment_masks();
        test_long_transfer();
        test_output_backpressure();
        test_random_traffic();

        wait_for_outputs();
        repeat (8) @(posedge i_clk);
        if (predicted_outputs.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, predicted_outputs.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

[i2c_register_read_sequencer_unit.f]
rtl/i2crs_pkg.sv
rtl/i2crs_apb_regs.sv
rtl/i2crs_seq_core.sv
rtl/i2crs_seq_core_top_placeholder.sv
rtl/i2c_register_read_sequencer_unit.sv
verif/tb.sv
